FILE: sv/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value table
// Command and status codes, beat layout, back-end sequencer states.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Default table geometry
  localparam int ENTRIES_DEF    = 128;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;

  // Beat layout (fixed field widths)
  localparam int FIELD_W       = 64;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int IN_TDATA_W    = 136;  // 2 + 64 + 64 = 130, padded to bytes
  localparam int OUT_TDATA_W   = 72;   // 2 + 64 = 66, padded to bytes
  localparam int IN_KEY_LSB    = 2;
  localparam int IN_VALUE_LSB  = 66;
  localparam int OUT_VALUE_LSB = 2;

  // Depth of the command queue between front and back (power of two)
  localparam int QDEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMP,
    BK_EXEC,
    BK_READ
  } bk_state_t;

  // Control strobes of the back-end sequencer
  typedef struct packed {
    logic    pop;
    logic    done;
    logic    wr_en;
    logic    clr_en;
    logic    rd_en;
    status_t status;
  } bk_ctrl_t;

endpackage

FILE: sv/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/kvt_front.sv
// ----------------------------------------------------------------------------
// kvt_front: command intake
// Accepts beats, decodes the command, trims key/value to table width and
// queues the result for the back end.
// ----------------------------------------------------------------------------
module kvt_front #(
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [kvt_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                          q_valid,
  input  logic                          q_pop,
  output kvt_pkg::cmd_t                 q_cmd,
  output logic [KEY_BITS-1:0]           q_key,
  output logic [VALUE_BITS-1:0]         q_value
);

  localparam int QPW = (kvt_pkg::QDEPTH > 1) ? $clog2(kvt_pkg::QDEPTH) : 1;

  kvt_pkg::cmd_t           cmd_q   [kvt_pkg::QDEPTH];
  logic [KEY_BITS-1:0]     key_q   [kvt_pkg::QDEPTH];
  logic [VALUE_BITS-1:0]   value_q [kvt_pkg::QDEPTH];

  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]   count_r,  count_nxt;
  logic           push;
  logic           pop;

  assign in_tready = (count_r != (QPW+1)'(kvt_pkg::QDEPTH));
  assign q_valid   = (count_r != '0);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage; unused upper key/value bits are dropped here
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]   <= kvt_pkg::cmd_t'(in_tdata[kvt_pkg::CMD_W-1:0]);
      key_q[wr_ptr_r]   <= in_tdata[kvt_pkg::IN_KEY_LSB +: KEY_BITS];
      value_q[wr_ptr_r] <= in_tdata[kvt_pkg::IN_VALUE_LSB +: VALUE_BITS];
    end
  end

  assign q_cmd   = cmd_q[rd_ptr_r];
  assign q_key   = key_q[rd_ptr_r];
  assign q_value = value_q[rd_ptr_r];

endmodule

FILE: sv/kvt_back.sv
// ----------------------------------------------------------------------------
// kvt_back: table execution
// Parallel key match over all slots, lowest-free-slot search, table update,
// value RAM access and the result register.
// ----------------------------------------------------------------------------
module kvt_back #(
  parameter int ENTRIES    = kvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  kvt_pkg::cmd_t         q_cmd,
  input  logic [KEY_BITS-1:0]   q_key,
  input  logic [VALUE_BITS-1:0] q_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output kvt_pkg::status_t      res_status,
  output logic [VALUE_BITS-1:0] res_value
);

  localparam int IW = $clog2(ENTRIES);

  kvt_pkg::bk_state_t state_r, state_nxt;
  kvt_pkg::bk_ctrl_t  ctrl;

  kvt_pkg::cmd_t         cur_cmd_r;
  logic [KEY_BITS-1:0]   cur_key_r;
  logic [VALUE_BITS-1:0] cur_value_r;

  logic [ENTRIES-1:0]  valid_r;
  logic [KEY_BITS-1:0] keys_r [ENTRIES];
  logic [ENTRIES-1:0]  match_r;
  logic [ENTRIES-1:0]  free_r;
  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  free_vec;

  logic          hit_any;
  logic          free_any;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  logic          out_can;

  logic                  res_valid_r;
  kvt_pkg::status_t      res_status_r;
  logic [VALUE_BITS-1:0] res_value_r;
  logic [VALUE_BITS-1:0] rd_data;

  // Compare stage: one comparator per slot, lowest free slot as a one-hot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (keys_r[i] == cur_key_r);
    end
    free_vec = ~valid_r & (valid_r + 1'b1);
  end

  // One-hot to index (at most one bit set in either vector)
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
      if (free_r[i]) begin
        free_idx = free_idx | IW'(i);
      end
    end
  end

  assign hit_any  = |match_r;
  assign free_any = |free_r;
  assign out_can  = !res_valid_r || res_ready;

  // Sequencer outputs
  always_comb begin
    ctrl        = '0;
    ctrl.status = kvt_pkg::ST_OK;
    case (state_r)
      kvt_pkg::BK_IDLE: begin
        ctrl.pop = q_valid;
      end
      kvt_pkg::BK_EXEC: begin
        case (cur_cmd_r)
          kvt_pkg::CMD_ADD: begin
            ctrl.done = out_can;
            if (hit_any) begin
              ctrl.status = kvt_pkg::ST_DUP;
            end else if (!free_any) begin
              ctrl.status = kvt_pkg::ST_FULL;
            end else begin
              ctrl.wr_en = out_can;
            end
          end
          kvt_pkg::CMD_REMOVE: begin
            ctrl.done   = out_can;
            ctrl.clr_en = out_can && hit_any;
            ctrl.status = hit_any ? kvt_pkg::ST_OK : kvt_pkg::ST_ABSENT;
          end
          kvt_pkg::CMD_LOOKUP: begin
            if (hit_any) begin
              ctrl.rd_en = 1'b1;
            end else begin
              ctrl.done   = out_can;
              ctrl.status = kvt_pkg::ST_ABSENT;
            end
          end
          default: begin
            ctrl.done = out_can;
          end
        endcase
        ctrl.pop = ctrl.done && q_valid;
      end
      kvt_pkg::BK_READ: begin
        ctrl.done = out_can;
        ctrl.pop  = out_can && q_valid;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kvt_pkg::BK_IDLE: begin
        if (ctrl.pop) begin
          state_nxt = kvt_pkg::BK_CMP;
        end
      end
      kvt_pkg::BK_CMP: begin
        state_nxt = kvt_pkg::BK_EXEC;
      end
      kvt_pkg::BK_EXEC, kvt_pkg::BK_READ: begin
        if (ctrl.rd_en) begin
          state_nxt = kvt_pkg::BK_READ;
        end else if (ctrl.pop) begin
          state_nxt = kvt_pkg::BK_CMP;
        end else if (ctrl.done) begin
          state_nxt = kvt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = kvt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvt_pkg::BK_IDLE;
      valid_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.wr_en) begin
        valid_r[free_idx] <= 1'b1;
      end else if (ctrl.clr_en) begin
        valid_r[hit_idx] <= 1'b0;
      end
      if (ctrl.done) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      cur_cmd_r   <= q_cmd;
      cur_key_r   <= q_key;
      cur_value_r <= q_value;
    end
    if (state_r == kvt_pkg::BK_CMP) begin
      match_r <= match_vec;
      free_r  <= free_vec;
    end
    if (ctrl.wr_en) begin
      keys_r[free_idx] <= cur_key_r;
    end
    if (ctrl.done) begin
      res_status_r <= ctrl.status;
      res_value_r  <= (state_r == kvt_pkg::BK_READ) ? rd_data : '0;
    end
  end

  kvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (free_idx),
    .wr_data (cur_value_r),
    .rd_en   (ctrl.rd_en),
    .rd_addr (hit_idx),
    .rd_data (rd_data)
  );

  assign q_pop      = ctrl.pop;
  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;
  assign res_value  = res_value_r;

endmodule

FILE: sv/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table: associative key/value store
// Fixed-capacity table of key/value pairs with add, remove and lookup
// commands; every command answers with one status beat.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+-------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: cmd[1:0] key[65:2] value[129:66]
//  out_    | out | out_tvalid/tready  | tdata: status[1:0] value_out[65:2]
//
//  Steps: add, remove and unused commands pass the back-end key compare
//  and execute steps; a lookup hit adds the value RAM read.
//  Reset clears the slot valid bits; key/value storage is not cleared
//  and is only read behind a set valid bit.
//  A two-beat command queue parts intake from execution. A waiting result
//  holds the back end in its execute or read step until out_tready.
//
//  Commands: 0 add, 1 remove, 2 lookup, 3 ignored (status ok).
//  Status:   0 ok, 1 key already present, 2 key absent, 3 table full.
//  Key bits above KEY_BITS and value bits above VALUE_BITS are ignored.
// ----------------------------------------------------------------------------
module key_value_table #(
  parameter int ENTRIES    = kvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command beats
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kvt_pkg::IN_TDATA_W-1:0]  in_tdata,   // cmd, key, value, pad
  // result beats
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kvt_pkg::OUT_TDATA_W-1:0] out_tdata   // status, value_out, pad
);

  logic                  q_valid;
  logic                  q_pop;
  kvt_pkg::cmd_t         q_cmd;
  logic [KEY_BITS-1:0]   q_key;
  logic [VALUE_BITS-1:0] q_value;

  kvt_pkg::status_t      res_status;
  logic [VALUE_BITS-1:0] res_value;

  // Intake: decode and queue commands
  kvt_front #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .q_key     (q_key),
    .q_value   (q_value)
  );

  // Execution: match, update, read, result register
  kvt_back #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .q_key      (q_key),
    .q_value    (q_value),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (res_status),
    .res_value  (res_value)
  );

  // Result beat packing; unused upper bits read zero
  always_comb begin
    out_tdata = '0;
    out_tdata[kvt_pkg::STATUS_W-1:0] = res_status;
    out_tdata[kvt_pkg::OUT_VALUE_LSB +: kvt_pkg::FIELD_W] = kvt_pkg::FIELD_W'(res_value);
  end

  // The back end never pops an empty queue
  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

  // Only a successful lookup carries a nonzero value
  a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[kvt_pkg::STATUS_W-1:0] != kvt_pkg::ST_OK))
      |-> (out_tdata[kvt_pkg::OUT_VALUE_LSB +: kvt_pkg::FIELD_W] == '0))
    else $error("nonzero value on a failed command");

  // Reset leaves no result pending and the queue empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !q_valid))
    else $error("result or queued command survives reset");

endmodule
